FILE: hdl/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants for the debounced button click detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bcd_pkg;

	localparam int unsigned CFG_ADDR_W = 5;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned IN_W       = 8;
	localparam int unsigned OUT_W      = 24;

	typedef enum logic [2:0] {
		EV_DOWN       = 3'd0,
		EV_UP         = 3'd1,
		EV_SINGLE     = 3'd3,
		EV_DOUBLE     = 3'd4,
		EV_LONG_START = 3'd5,
		EV_LONG_HOLD  = 3'd6,
		EV_NONE       = 3'd7
	} event_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_HELD     = 3'd1,
		ST_RELEASED = 3'd2,
		ST_REPEAT   = 3'd3,
		ST_LONG     = 3'd5
	} fsm_state_t;

	typedef enum logic [2:0] {
		REG_PRESS_LEVEL     = 3'd0,
		REG_SETTLE_TICKS    = 3'd1,
		REG_CLICK_GAP       = 3'd2,
		REG_HOLD_LIMIT      = 3'd3,
		REG_EVENTS_DISABLED = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        press_level;
		logic [2:0]  settle_ticks;
		logic [15:0] click_gap;
		logic [15:0] hold_limit;
		logic        events_disabled;
	} cfg_t;

	localparam logic        RST_PRESS_LEVEL     = 1'b0;
	localparam logic [2:0]  RST_SETTLE_TICKS    = 3'd5;
	localparam logic [15:0] RST_CLICK_GAP       = 16'd18;
	localparam logic [15:0] RST_HOLD_LIMIT      = 16'd50;
	localparam logic        RST_EVENTS_DISABLED = 1'b0;

	typedef struct packed {
		fsm_state_t  fsm;
		logic [15:0] tick;
		logic [7:0]  press;
		logic [2:0]  bounce;
		logic        stable;
		event_t      last_ev;
	} state_t;

	// Last member sits in the lowest bits of the packed word.
	typedef struct packed {
		logic       debounced_pressed;
		logic [7:0] click_count;
		event_t     current_event;
		logic       repeat_fired;
		event_t     fired_event;
		logic       fired_valid;
	} result_t;

	localparam int unsigned RES_W = $bits(result_t);

endpackage

`default_nettype wire

FILE: hdl/button_click_detector.sv
// ----------------------------------------------------------------------------
// button_click_detector
// Debounced button click detector: one raw level sample per transaction in,
// one event report per transaction out.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  s_*      | in        | one tick, tdata[0] raw_level
//  m_*      | out       | one event report per tick (fields listed at m_tdata)
//  apb p*   | in/out    | configuration registers at 4*index
//
//  One transaction per clock while m_tready does not stall; it passes the
//  input register, then the single next-state pass, then the result register.
//  Reset clears the machine, counters, valids and loads register defaults.
//  A stall on m_tready holds the result; the input register keeps taking a
//  transaction whenever the result register frees in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_detector (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire  [bcd_pkg::IN_W-1:0]        s_tdata,   // [0] raw_level
	output logic                            m_tvalid,
	input  wire                             m_tready,
	// [0] fired_valid, [3:1] fired_event, [4] repeat_fired, [7:5] current_event,
	// [15:8] click_count, [16] debounced_pressed, rest zero
	output logic [bcd_pkg::OUT_W-1:0]       m_tdata,
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire  [bcd_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire  [bcd_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [bcd_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import bcd_pkg::*;

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    valid_s1;
	logic    raw_s1;
	logic    m_valid_q;
	logic    advance;

	bcd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bcd_step u_step (
		.raw_level (raw_s1),
		.cfg       (cfg),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	assign advance  = valid_s1 & (~m_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_W - RES_W){1'b0}}, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			raw_s1 <= s_tdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.fsm     <= ST_IDLE;
			state_q.tick    <= '0;
			state_q.press   <= '0;
			state_q.bounce  <= '0;
			state_q.stable  <= 1'b0;
			state_q.last_ev <= EV_NONE;
			m_valid_q       <= 1'b0;
		end else if (advance) begin
			state_q   <= state_nxt;
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/bcd_regs.sv
// ----------------------------------------------------------------------------
// bcd_regs
// APB-style configuration register file for the click detector.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_regs (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [bcd_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire  [bcd_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [bcd_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready,
	output bcd_pkg::cfg_t                     cfg
);
	import bcd_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_level     <= RST_PRESS_LEVEL;
			cfg_q.settle_ticks    <= RST_SETTLE_TICKS;
			cfg_q.click_gap       <= RST_CLICK_GAP;
			cfg_q.hold_limit      <= RST_HOLD_LIMIT;
			cfg_q.events_disabled <= RST_EVENTS_DISABLED;
		end else if (wr_en) begin
			case (idx)
				REG_PRESS_LEVEL:     cfg_q.press_level     <= pwdata[0];
				REG_SETTLE_TICKS:    cfg_q.settle_ticks    <= pwdata[2:0];
				REG_CLICK_GAP:       cfg_q.click_gap       <= pwdata[15:0];
				REG_HOLD_LIMIT:      cfg_q.hold_limit      <= pwdata[15:0];
				REG_EVENTS_DISABLED: cfg_q.events_disabled <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_PRESS_LEVEL:     prdata = {31'd0, cfg_q.press_level};
			REG_SETTLE_TICKS:    prdata = {29'd0, cfg_q.settle_ticks};
			REG_CLICK_GAP:       prdata = {16'd0, cfg_q.click_gap};
			REG_HOLD_LIMIT:      prdata = {16'd0, cfg_q.hold_limit};
			REG_EVENTS_DISABLED: prdata = {31'd0, cfg_q.events_disabled};
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/bcd_step.sv
// ----------------------------------------------------------------------------
// bcd_step
// Next-state and result logic for one tick: debounce and click state machine.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_step (
	input  wire              raw_level,
	input  bcd_pkg::cfg_t    cfg,
	input  bcd_pkg::state_t  cur,
	output bcd_pkg::state_t  nxt,
	output bcd_pkg::result_t res
);
	import bcd_pkg::*;

	logic       raw_pressed;
	logic [2:0] bounce_inc;
	logic       fired;
	logic       rep;
	event_t     ev;
	logic       en;

	assign raw_pressed = (raw_level == cfg.press_level);
	assign bounce_inc  = cur.bounce + 3'd1;
	assign en          = ~cfg.events_disabled;

	always_comb begin
		nxt   = cur;
		fired = 1'b0;
		rep   = 1'b0;
		ev    = EV_NONE;

		if (cur.fsm != ST_IDLE) begin
			nxt.tick = cur.tick + 16'd1;
		end

		// debounce
		if (raw_pressed != cur.stable) begin
			nxt.bounce = bounce_inc;
			if (bounce_inc >= cfg.settle_ticks) begin
				nxt.stable = raw_pressed;
				nxt.bounce = '0;
			end
		end else begin
			nxt.bounce = '0;
		end

		case (cur.fsm)
			ST_IDLE: begin
				if (nxt.stable) begin
					nxt.last_ev = EV_DOWN;
					fired       = 1'b1;
					ev          = EV_DOWN;
					nxt.tick    = '0;
					nxt.press   = 8'd1;
					nxt.fsm     = ST_HELD;
				end else begin
					nxt.last_ev = EV_NONE;
				end
			end
			ST_HELD: begin
				if (!nxt.stable) begin
					nxt.last_ev = EV_UP;
					fired       = 1'b1;
					ev          = EV_UP;
					nxt.tick    = '0;
					nxt.fsm     = ST_RELEASED;
				end else if (nxt.tick > cfg.hold_limit) begin
					nxt.last_ev = EV_LONG_START;
					fired       = 1'b1;
					ev          = EV_LONG_START;
					nxt.fsm     = ST_LONG;
				end
			end
			ST_RELEASED: begin
				if (nxt.stable) begin
					nxt.last_ev = EV_DOWN;
					fired       = 1'b1;
					ev          = EV_DOWN;
					nxt.press   = cur.press + 8'd1;
					rep         = 1'b1;
					nxt.tick    = '0;
					nxt.fsm     = ST_REPEAT;
				end else if (nxt.tick > cfg.click_gap) begin
					if (cur.press == 8'd1) begin
						nxt.last_ev = EV_SINGLE;
						fired       = 1'b1;
						ev          = EV_SINGLE;
					end else if (cur.press == 8'd2) begin
						nxt.last_ev = EV_DOUBLE;
						fired       = 1'b1;
						ev          = EV_DOUBLE;
					end
					nxt.fsm = ST_IDLE;
				end
			end
			ST_REPEAT: begin
				if (!nxt.stable) begin
					nxt.last_ev = EV_UP;
					fired       = 1'b1;
					ev          = EV_UP;
					if (nxt.tick < cfg.click_gap) begin
						nxt.tick = '0;
						nxt.fsm  = ST_RELEASED;
					end else begin
						nxt.fsm = ST_IDLE;
					end
				end
			end
			ST_LONG: begin
				fired = 1'b1;
				if (nxt.stable) begin
					nxt.last_ev = EV_LONG_HOLD;
					ev          = EV_LONG_HOLD;
				end else begin
					nxt.last_ev = EV_UP;
					ev          = EV_UP;
					nxt.fsm     = ST_IDLE;
				end
			end
			default: begin
				nxt.fsm = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res.fired_valid       = fired & en;
		res.fired_event       = (fired & en) ? ev : EV_NONE;
		res.repeat_fired      = rep & en;
		res.current_event     = nxt.last_ev;
		res.click_count       = nxt.press;
		res.debounced_pressed = nxt.stable;
	end

endmodule

`default_nettype wire

FILE: hdl/bcd_checker.sv
// ----------------------------------------------------------------------------
// bcd_checker
// Port-level checks for the click detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             m_tvalid,
	input wire                             m_tready,
	input wire [bcd_pkg::OUT_W-1:0]        m_tdata
);
	import bcd_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no fired event reads as none
	a_quiet_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[3:1] == EV_NONE)
		else $error("event code without fired flag");

	// a repeat press is always a down event
	a_repeat_down: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[0] && m_tdata[3:1] == EV_DOWN)
		else $error("repeat without down event");

	// a fired event is also the recorded event
	a_fired_recorded: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[7:5] == m_tdata[3:1])
		else $error("fired event not recorded");

endmodule

bind button_click_detector bcd_checker u_bcd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
